/* rtl/hkl_pkg.sv */
// ----------------------------------------------------------------------------
// hkl_pkg
// shared types, codes and the lock key decoder of the keyboard lock led tracker
// ----------------------------------------------------------------------------
package hkl_pkg;

	// operation codes carried in the input tuser
	typedef enum logic [1:0] {
		OP_REPORT_BYTE = 2'd0,
		OP_READ        = 2'd1,
		OP_SET_LED     = 2'd2,
		OP_CLEAR       = 2'd3
	} hkl_op_t;

	// result kinds carried in the output tuser
	typedef enum logic [1:0] {
		KIND_LED        = 2'd0,
		KIND_COUNT      = 2'd1,
		KIND_PAYLOAD    = 2'd2,
		KIND_LED_REPORT = 2'd3
	} hkl_kind_t;

	// read sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_PAYLOAD
	} hkl_state_t;

	// configuration register indexes
	localparam logic REG_PAYLOAD_SIZE = 1'b0;
	localparam logic REG_LOCK_MODE    = 1'b1;

	// lock modes
	localparam logic [1:0] MODE_OFF        = 2'd0;
	localparam logic [1:0] MODE_CAPS       = 2'd1;
	localparam logic [1:0] MODE_CAPS_SHIFT = 2'd2;

	// lock keycodes
	localparam logic [7:0] KEY_NUM_LOCK    = 8'h53;
	localparam logic [7:0] KEY_CAPS_LOCK   = 8'h39;
	localparam logic [7:0] KEY_SCROLL_LOCK = 8'h47;
	localparam logic [7:0] KEY_LEFT_GUI    = 8'hE3;
	localparam logic [7:0] KEY_KANA        = 8'h90;

	localparam logic [7:0] SHIFT_MASK = 8'h22;

	localparam int LOCK_W = 5;

	localparam logic [LOCK_W-1:0] LOCK_NUM    = 5'h01;
	localparam logic [LOCK_W-1:0] LOCK_CAPS   = 5'h02;
	localparam logic [LOCK_W-1:0] LOCK_SCROLL = 5'h04;
	localparam logic [LOCK_W-1:0] LOCK_GUI    = 5'h08;
	localparam logic [LOCK_W-1:0] LOCK_KANA   = 5'h10;

	// first keycode position within a report
	localparam int KEY_START = 2;

	// outcome of a report byte, from the lock tracker to the ring
	typedef struct packed {
		logic       done;      // report ended without transfer error
		logic       led_sent;  // lock key set changed, an led report goes out
		logic [7:0] led;       // led pattern after this report
	} hkl_commit_t;

	function automatic logic [LOCK_W-1:0] key_bits(input logic [7:0] key,
	                                               input logic [1:0] mode,
	                                               input logic [7:0] modifier);
		logic caps_on;
		caps_on = (mode == MODE_CAPS) ||
		          ((mode == MODE_CAPS_SHIFT) && ((modifier & SHIFT_MASK) != 8'h00));
		case (key)
			KEY_CAPS_LOCK:   key_bits = caps_on ? LOCK_CAPS : '0;
			KEY_SCROLL_LOCK: key_bits = LOCK_SCROLL;
			KEY_NUM_LOCK:    key_bits = LOCK_NUM;
			KEY_KANA:        key_bits = LOCK_KANA;
			KEY_LEFT_GUI:    key_bits = LOCK_GUI;
			default:         key_bits = '0;
		endcase
	endfunction

endpackage

/* rtl/hkl_report_ram.sv */
// ----------------------------------------------------------------------------
// hkl_report_ram
// payload byte memory, one write and one registered read port
// ----------------------------------------------------------------------------
module hkl_report_ram #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/hkl_lock_track.sv */
// ----------------------------------------------------------------------------
// hkl_lock_track
// report byte position, modifier, lock key masks and the led pattern
// ----------------------------------------------------------------------------
module hkl_lock_track #(
	parameter int POS_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  logic                set_en,
	input  logic [7:0]          data,
	input  logic                last,
	input  logic                err,
	input  logic [POS_W-1:0]    eff_payload,
	input  logic [1:0]          lock_mode,
	output logic [POS_W-1:0]    pos,
	output logic                store,
	output logic [POS_W-1:0]    count,
	output logic [7:0]          led,
	output hkl_pkg::hkl_commit_t commit
);

	logic [POS_W-1:0]           pos_q;
	logic [7:0]                 modifier_q;
	logic [hkl_pkg::LOCK_W-1:0] pending_q;
	logic [hkl_pkg::LOCK_W-1:0] previous_q;
	logic [7:0]                 led_q;

	logic [POS_W-1:0]           pos_next;
	logic [hkl_pkg::LOCK_W-1:0] key;
	logic [hkl_pkg::LOCK_W-1:0] mask_next;
	logic                       finish;
	logic                       done;
	logic                       change;
	logic [7:0]                 led_new;

	// bytes past the payload size are neither kept nor scanned
	assign store    = byte_en && (pos_q < eff_payload);
	assign pos_next = store ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		if (store && (pos_q >= POS_W'(hkl_pkg::KEY_START))) begin
			key = hkl_pkg::key_bits(data, lock_mode, modifier_q);
		end else begin
			key = '0;
		end
	end

	assign mask_next = pending_q | key;
	assign finish    = byte_en && last;
	assign done      = finish && !err;
	assign change    = (previous_q != mask_next) && (lock_mode != hkl_pkg::MODE_OFF);
	assign led_new   = change ? (led_q ^ 8'(mask_next)) : led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			modifier_q <= '0;
			pending_q  <= '0;
			previous_q <= '0;
			led_q      <= '0;
		end else begin
			if (store && (pos_q == '0)) begin
				modifier_q <= data;
			end
			if (finish) begin
				pos_q     <= '0;
				pending_q <= '0;
			end else begin
				pos_q     <= pos_next;
				pending_q <= mask_next;
			end
			if (done && change) begin
				previous_q <= mask_next;
				led_q      <= led_new;
			end
			if (set_en) begin
				led_q <= data;
			end
		end
	end

	assign pos             = pos_q;
	assign count           = pos_next;
	assign led             = led_q;
	assign commit.done     = done;
	assign commit.led_sent = done && change;
	assign commit.led      = led_new;

endmodule

/* rtl/hid_keyboard_lock_led_and_report_ring.sv */
// ----------------------------------------------------------------------------
// hid_keyboard_lock_led_and_report_ring
// keyboard report lock key tracker with led control and a report ring
// ----------------------------------------------------------------------------
// timing: report byte, set led and clear are single words; a result is
//   registered and shows in the cycle after the word that caused it is taken
// throughput: if the output is free, one word per cycle; a read holds input
//   until its results are out, one per cycle via the payload ram read port
// reset: all control state cleared at once, no clearing pass; payload ram
//   holds garbage, bytes past an entry's count are forced to zero on read
// ----------------------------------------------------------------------------
module hid_keyboard_lock_led_and_report_ring #(
	parameter int PAYLOAD_MAX = 8,
	parameter int RING_DEPTH  = 3
) (
	input  logic       clk,
	input  logic       arst_n,

	// configuration
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,

	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic [2:0] s_tuser,   // operation [1:0], transfer_error [2]
	input  logic       s_tlast,   // last byte of a report

	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // value
	output logic [1:0] m_tuser,   // kind [1:0]
	output logic       m_tlast    // last result of one input word
);

	localparam int POS_W     = $clog2(PAYLOAD_MAX + 1);
	localparam int SLOT_W    = $clog2(RING_DEPTH);
	localparam int PHYS_W    = $clog2(RING_DEPTH + 1);
	localparam int FILL_W    = $clog2(RING_DEPTH + 1);
	localparam int MEM_DEPTH = (RING_DEPTH + 1) * PAYLOAD_MAX;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

	// configuration registers
	logic [3:0] payload_size_q;
	logic [1:0] lock_mode_q;
	logic [POS_W-1:0] eff_payload;

	// ring bookkeeping; payload bytes live in ram slots reached through
	// slot_map_q, with one spare ram slot taking the report in progress
	logic [SLOT_W-1:0] write_slot_q;
	logic [SLOT_W-1:0] read_slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [PHYS_W-1:0] slot_map_q [RING_DEPTH];
	logic [PHYS_W-1:0] stage_phys_q;
	logic [7:0]        ring_led_q [RING_DEPTH];
	logic [POS_W-1:0]  ring_cnt_q [RING_DEPTH];

	// read sequencer
	hkl_pkg::hkl_state_t state_q;
	hkl_pkg::hkl_state_t state_next;
	logic [POS_W-1:0]    rd_cnt_q;
	logic [PHYS_W-1:0]   rd_phys_q;
	logic [POS_W-1:0]    rd_pay_q;
	logic [POS_W-1:0]    idx_q;
	logic [POS_W-1:0]    rd_idx;
	logic                last_byte;

	// output register
	logic                m_tvalid_q;
	logic [7:0]          value_q;
	hkl_pkg::hkl_kind_t  kind_q;
	logic                end_q;
	logic                out_free;
	logic                out_load;
	hkl_pkg::hkl_kind_t  out_kind;
	logic [7:0]          out_value;
	logic                out_end;

	// input side
	logic                accept;
	hkl_pkg::hkl_op_t    op;
	logic [SLOT_W-1:0]   sel_slot;
	logic [PHYS_W-1:0]   sel_phys;

	// lock tracker
	logic [POS_W-1:0]     pos;
	logic                 store;
	logic [POS_W-1:0]     count;
	logic [7:0]           led;
	hkl_pkg::hkl_commit_t commit;

	// ram
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [7:0]           ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_size_q <= 4'd8;
			lock_mode_q    <= hkl_pkg::MODE_CAPS;
		end else if (cfg_we) begin
			case (cfg_index)
				hkl_pkg::REG_PAYLOAD_SIZE: payload_size_q <= cfg_data;
				hkl_pkg::REG_LOCK_MODE:    lock_mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// payload size saturates at the ram slot size
	always_comb begin
		if (32'(payload_size_q) > PAYLOAD_MAX) begin
			eff_payload = POS_W'(PAYLOAD_MAX);
		end else begin
			eff_payload = POS_W'(payload_size_q);
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == hkl_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign op       = hkl_pkg::hkl_op_t'(s_tuser[1:0]);

	// a read looks at the oldest entry, a report commit at the write slot
	assign sel_slot = (op == hkl_pkg::OP_READ) ? read_slot_q : write_slot_q;
	assign sel_phys = slot_map_q[sel_slot];

	hkl_lock_track #(
		.POS_W (POS_W)
	) u_lock_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_en     (accept && (op == hkl_pkg::OP_REPORT_BYTE)),
		.set_en      (accept && (op == hkl_pkg::OP_SET_LED)),
		.data        (s_tdata),
		.last        (s_tlast),
		.err         (s_tuser[2]),
		.eff_payload (eff_payload),
		.lock_mode   (lock_mode_q),
		.pos         (pos),
		.store       (store),
		.count       (count),
		.led         (led),
		.commit      (commit)
	);

	// report bytes go straight into the spare ram slot
	assign ram_waddr = ADDR_W'(stage_phys_q) * ADDR_W'(PAYLOAD_MAX) + ADDR_W'(pos);

	// next payload byte to fetch: first one while the count goes out
	assign rd_idx    = (state_q == hkl_pkg::ST_COUNT) ? '0 : idx_q + POS_W'(1);
	assign ram_raddr = ADDR_W'(rd_phys_q) * ADDR_W'(PAYLOAD_MAX) + ADDR_W'(rd_idx);
	assign last_byte = (idx_q + POS_W'(1)) == rd_pay_q;

	assign ram_re = out_free &&
	                (((state_q == hkl_pkg::ST_COUNT) && (rd_pay_q != '0)) ||
	                 ((state_q == hkl_pkg::ST_PAYLOAD) && !last_byte));

	hkl_report_ram #(
		.DEPTH  (MEM_DEPTH),
		.ADDR_W (ADDR_W)
	) u_report_ram (
		.clk   (clk),
		.we    (store),
		.waddr (ram_waddr),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ring pointers and slot map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			fill_q       <= '0;
			stage_phys_q <= PHYS_W'(RING_DEPTH);
			for (int i = 0; i < RING_DEPTH; i++) begin
				slot_map_q[i] <= PHYS_W'(i);
			end
		end else if (accept) begin
			case (op)
				hkl_pkg::OP_REPORT_BYTE: begin
					if (commit.done) begin
						// finished report takes the write slot, the slot's old
						// ram space becomes the spare
						slot_map_q[write_slot_q] <= stage_phys_q;
						stage_phys_q <= sel_phys;
						write_slot_q <= (write_slot_q == SLOT_LAST) ? '0 :
						                write_slot_q + SLOT_W'(1);
						if (fill_q == FILL_FULL) begin
							// full: oldest entry overwritten
							read_slot_q <= (read_slot_q == SLOT_LAST) ? '0 :
							               read_slot_q + SLOT_W'(1);
						end else begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				hkl_pkg::OP_READ: begin
					if (fill_q != '0) begin
						read_slot_q <= (read_slot_q == SLOT_LAST) ? '0 :
						               read_slot_q + SLOT_W'(1);
						fill_q <= fill_q - FILL_W'(1);
					end
				end
				hkl_pkg::OP_CLEAR: begin
					write_slot_q <= '0;
					read_slot_q  <= '0;
					fill_q       <= '0;
				end
				default: ;
			endcase
		end
	end

	// entry led byte and count
	always_ff @(posedge clk) begin
		if (accept && (op == hkl_pkg::OP_REPORT_BYTE) && commit.done) begin
			ring_led_q[write_slot_q] <= commit.led;
			ring_cnt_q[write_slot_q] <= count;
		end
	end

	// read sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hkl_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			hkl_pkg::ST_IDLE: begin
				if (accept && (op == hkl_pkg::OP_READ)) begin
					state_next = hkl_pkg::ST_COUNT;
				end
			end
			hkl_pkg::ST_COUNT: begin
				if (out_free) begin
					state_next = (rd_pay_q == '0) ? hkl_pkg::ST_IDLE : hkl_pkg::ST_PAYLOAD;
				end
			end
			hkl_pkg::ST_PAYLOAD: begin
				if (out_free && last_byte) begin
					state_next = hkl_pkg::ST_IDLE;
				end
			end
			default: state_next = hkl_pkg::ST_IDLE;
		endcase
	end

	// snapshot of the entry being read; empty ring reads as count zero
	always_ff @(posedge clk) begin
		if (accept && (op == hkl_pkg::OP_READ)) begin
			rd_cnt_q  <= (fill_q == '0) ? '0 : ring_cnt_q[sel_slot];
			rd_phys_q <= sel_phys;
			rd_pay_q  <= eff_payload;
		end
		if (out_free && (state_q == hkl_pkg::ST_COUNT)) begin
			idx_q <= '0;
		end else if (out_free && (state_q == hkl_pkg::ST_PAYLOAD)) begin
			idx_q <= idx_q + POS_W'(1);
		end
	end

	// result selection
	always_comb begin
		out_load  = 1'b0;
		out_kind  = hkl_pkg::KIND_LED;
		out_value = '0;
		out_end   = 1'b0;
		case (state_q)
			hkl_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						hkl_pkg::OP_REPORT_BYTE: begin
							out_load  = commit.led_sent;
							out_kind  = hkl_pkg::KIND_LED_REPORT;
							out_value = commit.led;
							out_end   = 1'b1;
						end
						hkl_pkg::OP_READ: begin
							out_load  = 1'b1;
							out_kind  = hkl_pkg::KIND_LED;
							out_value = (fill_q == '0) ? led : ring_led_q[sel_slot];
						end
						hkl_pkg::OP_SET_LED: begin
							out_load  = 1'b1;
							out_kind  = hkl_pkg::KIND_LED_REPORT;
							out_value = s_tdata;
							out_end   = 1'b1;
						end
						default: ;
					endcase
				end
			end
			hkl_pkg::ST_COUNT: begin
				out_load  = out_free;
				out_kind  = hkl_pkg::KIND_COUNT;
				out_value = 8'(rd_cnt_q);
				out_end   = (rd_pay_q == '0);
			end
			hkl_pkg::ST_PAYLOAD: begin
				// bytes past the entry's count read as zero
				out_load  = out_free;
				out_kind  = hkl_pkg::KIND_PAYLOAD;
				out_value = (idx_q < rd_cnt_q) ? ram_rdata : 8'h00;
				out_end   = last_byte;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q  <= out_kind;
			value_q <= out_value;
			end_q   <= out_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = end_q;

endmodule
